@@ src/fct_pkg.sv @@
// Shared types and action codes for the fault code table.
package fct_pkg;

  localparam logic [2:0] ACT_WRITE  = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_FREE   = 3'd2;
  localparam logic [2:0] ACT_COUNT  = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [18:0] param_number;
    logic [4:0]  fail_mode;
    logic        active_flag;
    logic        occupied_flag;
  } in_item_t;

  typedef struct packed {
    logic [4:0] value;
    logic       found;
  } out_item_t;

  // Stored part of one entry; the occupied bit lives in flip-flops.
  typedef struct packed {
    logic [18:0] number;
    logic [4:0]  mode;
    logic        active;
  } entry_t;

endpackage

@@ src/fault_code_table_top.sv @@
// Fault code table: entry memory, occupied bits and the sequencer that walks them.
//
// A write takes effect at the accepting edge and its result beat appears in the next
// cycle; busy stays low. Lookup, find free, count and clear inactive read the entry
// memory one slot per cycle through its single read port, so busy is high from the
// accepting edge through S_WALK, S_DRAIN and S_FIN, and the result beat appears
// as busy drops. Results are shown for one cycle on out_strobe and cannot be
// held off; the next item may be started in the same cycle as a result beat. The
// occupied bits are flip-flops cleared by reset, so no clearing pass is needed.
module fault_code_table_top #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fct_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output fct_pkg::out_item_t  out_item
);

  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W = 9;
  localparam logic [CNT_W-1:0] SIZE_V = CNT_W'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  fct_pkg::entry_t mem [TABLE_SIZE];

  logic [1:0]            state_r, state_nxt;
  fct_pkg::in_item_t     req_r;
  logic [IDX_W-1:0]      rd_addr_r;
  fct_pkg::entry_t       rd_data_r;
  logic                  chk_vld_r;
  logic [IDX_W-1:0]      chk_idx_r;
  logic [TABLE_SIZE-1:0] used_r;
  logic                  found_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  out_strobe_r;
  fct_pkg::out_item_t    out_item_r;

  logic                  accept;
  logic [CNT_W-1:0]      slot_ext;
  logic                  wr_ok;
  logic [IDX_W-1:0]      wr_idx;
  logic                  chk_used;
  logic                  lookup_hit;
  logic [CNT_W-1:0]      hit_ext;

  assign accept     = start && !busy;
  assign busy       = (state_r != S_IDLE);
  assign slot_ext   = CNT_W'(in_item.slot);
  assign wr_ok      = accept && (in_item.action == fct_pkg::ACT_WRITE) && (slot_ext < SIZE_V);
  assign wr_idx     = slot_ext[IDX_W-1:0];
  assign chk_used   = used_r[chk_idx_r];
  assign lookup_hit = chk_used && (rd_data_r.number == req_r.param_number)
                      && (rd_data_r.mode == req_r.fail_mode);
  assign hit_ext    = CNT_W'(hit_idx_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_item.action inside {fct_pkg::ACT_LOOKUP, fct_pkg::ACT_FREE,
                                              fct_pkg::ACT_COUNT, fct_pkg::ACT_CLEAR})) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (rd_addr_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Entry memory: one write port used only when idle, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_idx] <= '{number: in_item.param_number, mode: in_item.fail_mode,
                       active: in_item.active_flag};
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      chk_vld_r    <= 1'b0;
      used_r       <= '0;
      found_r      <= 1'b0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
      rd_addr_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      chk_vld_r    <= (state_r == S_WALK);
      // writes and unused codes answer at once; walks answer from S_FIN
      out_strobe_r <= (accept && (state_nxt == S_IDLE)) || (state_r == S_FIN);
      if (accept) begin
        found_r   <= 1'b0;
        cnt_r     <= '0;
        rd_addr_r <= '0;
      end
      if (wr_ok) begin
        used_r[wr_idx] <= in_item.occupied_flag;
      end
      if (state_r == S_WALK && rd_addr_r != LAST_IDX) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      // Check stage: one entry per cycle, using the data and index registered from the read address.
      if (chk_vld_r) begin
        case (req_r.action)
          fct_pkg::ACT_LOOKUP: begin
            if (lookup_hit && !found_r) begin
              found_r <= 1'b1;
            end
          end
          fct_pkg::ACT_FREE: begin
            if (!chk_used && !found_r) begin
              found_r <= 1'b1;
            end
          end
          fct_pkg::ACT_COUNT: begin
            if (chk_used && (rd_data_r.active == req_r.active_flag)) begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
          fct_pkg::ACT_CLEAR: begin
            if (chk_used && !rd_data_r.active) begin
              used_r[chk_idx_r] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
    chk_idx_r <= rd_addr_r;
    if (chk_vld_r && !found_r &&
        ((req_r.action == fct_pkg::ACT_LOOKUP && lookup_hit) ||
         (req_r.action == fct_pkg::ACT_FREE && !chk_used))) begin
      hit_idx_r <= chk_idx_r;
    end
    if (accept) begin
      out_item_r <= '0;
    end else if (state_r == S_FIN) begin
      out_item_r.found <= found_r;
      case (req_r.action)
        fct_pkg::ACT_LOOKUP,
        fct_pkg::ACT_FREE:  out_item_r.value <= found_r ? hit_ext[4:0] : SIZE_V[4:0];
        fct_pkg::ACT_COUNT: out_item_r.value <= cnt_r[4:0];
        default:            out_item_r.value <= '0;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.action == fct_pkg::ACT_COUNT || in_item.action == fct_pkg::ACT_CLEAR
               || in_item.action == fct_pkg::ACT_LOOKUP || in_item.action == fct_pkg::ACT_FREE)
    |=> busy && !out_strobe)
    else $error("walk action did not raise busy");

  a_chk_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (state_r == S_WALK || state_r == S_DRAIN))
    else $error("check stage active outside a walk");

  a_found_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.found
    |-> (req_r.action == fct_pkg::ACT_LOOKUP || req_r.action == fct_pkg::ACT_FREE))
    else $error("found set for an action that does not search");

  a_fin_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> out_strobe && !busy)
    else $error("walk ended without a result beat");

endmodule
